// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, held off during reset
`define DBF_ASSERT_IF(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// implication in the next cycle, held off during reset
`define DBF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/dbf_pkg.sv
package dbf_pkg;

  localparam int MAX_CLASSES = 256;
  localparam int CLS_W       = $clog2(MAX_CLASSES);

  localparam int MID_DEPTH  = 4;
  localparam int MID_PTR_W  = $clog2(MID_DEPTH);
  localparam int MID_CNT_W  = $clog2(MID_DEPTH + 2);

  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 3);

  localparam logic signed [31:0] ONE_AND_HALF = 32'sh0001_8000;
  localparam logic [28:0]        ONE_PIXEL    = 29'h0001_0000;

  typedef enum logic [0:0] {
    OP_DETECT    = 1'b0,
    OP_THR_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_NUM_CLASSES  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [8:0]  num_classes;
  } cfg_t;

  // classified row waiting for the back end
  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] y_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_max;
    logic [15:0]        score;
    logic [CLS_W-1:0]   cls;
    logic               norm;
  } row_t;

  typedef struct packed {
    logic                 empty;
    logic [MID_CNT_W-1:0] count;
  } qstat_t;

endpackage

// File: rtl/detection_box_filter_core.sv
// path: a kept row passes the read stage, queue, stages a and b, result queue
// throughput: one row or threshold write per cycle when not full, set by the
//   read stage and the three-stage back end (scale multiply, clamp, extent check)
// reset: asynchronous active low; queues empty, config back to 640 x 640 with
//   80 classes, threshold valid bits cleared so every class threshold reads 0
module detection_box_filter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input queue side
  input  logic               push,
  output logic               full,
  input  logic               opcode_i,
  input  logic signed [31:0] x_min_i,
  input  logic signed [31:0] y_min_i,
  input  logic signed [31:0] x_max_i,
  input  logic signed [31:0] y_max_i,
  input  logic [15:0]        score_i,
  input  logic signed [15:0] class_index_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic [28:0]        box_left_o,
  output logic [28:0]        box_top_o,
  output logic [28:0]        box_width_o,
  output logic [28:0]        box_height_o,
  output logic [15:0]        confidence_o,
  output logic [7:0]         class_id_o,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i
);

  dbf_pkg::cfg_t   cfg_q;
  dbf_pkg::row_t   mid_row_in, mid_row_out;
  dbf_pkg::qstat_t mid_status;
  logic            mid_push, mid_pop;

  // config regs: writes always taken; users must write only while the block is idle, the block does not check
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 13'd640;
      cfg_q.num_classes  <= 9'd80;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbf_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        dbf_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        dbf_pkg::CFG_NUM_CLASSES:  cfg_q.num_classes  <= cfg_data_i[8:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front: threshold table, class range and score test
  dbf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .x_min_i       (x_min_i),
    .y_min_i       (y_min_i),
    .x_max_i       (x_max_i),
    .y_max_i       (y_max_i),
    .score_i       (score_i),
    .class_index_i (class_index_i),
    .num_classes_i (cfg_q.num_classes),
    .q_status_i    (mid_status),
    .q_push_o      (mid_push),
    .q_row_o       (mid_row_in)
  );

  // short queue decoupling classification from box math
  dbf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (mid_push),
    .row_i    (mid_row_in),
    .pop_i    (mid_pop),
    .row_o    (mid_row_out),
    .status_o (mid_status)
  );

  // back: scale, clamp, extent check and result queue
  dbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .row_i        (mid_row_out),
    .q_status_i   (mid_status),
    .q_pop_o      (mid_pop),
    .empty        (empty),
    .pop          (pop),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .confidence_o (confidence_o),
    .class_id_o   (class_id_o)
  );

endmodule

// File: rtl/dbf_queue.sv
module dbf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dbf_pkg::row_t  row_i,
  input  logic           pop_i,
  output dbf_pkg::row_t  row_o,
  output dbf_pkg::qstat_t status_o
);

  dbf_pkg::row_t                       entries_q [dbf_pkg::MID_DEPTH];
  logic [dbf_pkg::MID_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [dbf_pkg::MID_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [dbf_pkg::MID_CNT_W-1:0]       count_q, count_d;
  logic                                do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + dbf_pkg::MID_CNT_W'(push_i) - dbf_pkg::MID_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= row_i;
    end
  end

  assign row_o           = entries_q[rd_ptr_q];
  assign status_o.empty  = (count_q == '0);
  assign status_o.count  = count_q;

endmodule

// File: rtl/dbf_front.sv
module dbf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                opcode_i,
  input  logic signed [31:0]  x_min_i,
  input  logic signed [31:0]  y_min_i,
  input  logic signed [31:0]  x_max_i,
  input  logic signed [31:0]  y_max_i,
  input  logic [15:0]         score_i,
  input  logic signed [15:0]  class_index_i,
  input  logic [8:0]          num_classes_i,
  input  dbf_pkg::qstat_t     q_status_i,
  output logic                q_push_o,
  output dbf_pkg::row_t       q_row_o
);

  logic [15:0]                  thr_mem [dbf_pkg::MAX_CLASSES];
  logic [dbf_pkg::MAX_CLASSES-1:0] thr_vld_q;
  logic [dbf_pkg::CLS_W-1:0]    idx;
  logic                         accept;
  logic                         idx_in_table;
  logic                         thr_wr;
  logic                         cls_ok;
  logic [dbf_pkg::MID_CNT_W-1:0] pending;

  logic                         s1_valid_q;
  logic                         s1_ok_q;
  logic                         s1_seen_q;
  logic [15:0]                  s1_thr_q;
  logic signed [31:0]           s1_x_min_q, s1_y_min_q, s1_x_max_q, s1_y_max_q;
  logic [15:0]                  s1_score_q;
  logic [dbf_pkg::CLS_W-1:0]    s1_cls_q;
  logic [15:0]                  s1_thr;

  // credit: queue fill plus the row held in the read stage
  assign pending = q_status_i.count + dbf_pkg::MID_CNT_W'(s1_valid_q);
  assign full    = pending >= dbf_pkg::MID_CNT_W'(dbf_pkg::MID_DEPTH);
  assign accept  = push && !full;

  assign idx          = class_index_i[dbf_pkg::CLS_W-1:0];
  assign idx_in_table = (class_index_i >= 16'sd0) &&
                        (class_index_i < 16'(dbf_pkg::MAX_CLASSES));
  assign thr_wr       = accept && (opcode_i == dbf_pkg::OP_THR_WRITE) && idx_in_table;
  assign cls_ok       = (opcode_i == dbf_pkg::OP_DETECT) && idx_in_table &&
                        (class_index_i < $signed({7'b0, num_classes_i}));

  always_ff @(posedge clk_i) begin
    if (thr_wr) begin
      thr_mem[idx] <= score_i;
    end
    s1_thr_q <= thr_mem[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_vld_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (thr_wr) begin
        thr_vld_q[idx] <= 1'b1;
      end
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q    <= cls_ok;
    s1_seen_q  <= thr_vld_q[idx];
    s1_x_min_q <= x_min_i;
    s1_y_min_q <= y_min_i;
    s1_x_max_q <= x_max_i;
    s1_y_max_q <= y_max_i;
    s1_score_q <= score_i;
    s1_cls_q   <= idx;
  end

  // entries never written read as zero
  assign s1_thr   = s1_seen_q ? s1_thr_q : 16'd0;
  assign q_push_o = s1_valid_q && s1_ok_q && (s1_score_q >= s1_thr);

  always_comb begin
    q_row_o.x_min = s1_x_min_q;
    q_row_o.y_min = s1_y_min_q;
    q_row_o.x_max = s1_x_max_q;
    q_row_o.y_max = s1_y_max_q;
    q_row_o.score = s1_score_q;
    q_row_o.cls   = s1_cls_q;
    q_row_o.norm  = (s1_x_max_q <= dbf_pkg::ONE_AND_HALF) &&
                    (s1_y_max_q <= dbf_pkg::ONE_AND_HALF);
  end

endmodule

// File: rtl/dbf_back.sv
module dbf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dbf_pkg::cfg_t    cfg_i,
  input  dbf_pkg::row_t    row_i,
  input  dbf_pkg::qstat_t  q_status_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [28:0]      box_left_o,
  output logic [28:0]      box_top_o,
  output logic [28:0]      box_width_o,
  output logic [28:0]      box_height_o,
  output logic [15:0]      confidence_o,
  output logic [7:0]       class_id_o
);

  typedef struct packed {
    logic [28:0] left;
    logic [28:0] top;
    logic [28:0] width;
    logic [28:0] height;
    logic [15:0] conf;
    logic [7:0]  cls;
  } box_t;

  function automatic logic [28:0] clamp_dim(input logic signed [45:0] v,
                                            input logic [28:0] hi);
    logic [28:0] r;
    if (v[45]) begin
      r = '0;
    end else if (v > $signed({17'b0, hi})) begin
      r = hi;
    end else begin
      r = v[28:0];
    end
    return r;
  endfunction

  logic [dbf_pkg::OUT_CNT_W-1:0] out_count_q, out_count_d;
  logic [dbf_pkg::OUT_PTR_W-1:0] out_wr_q, out_rd_q;
  box_t                          out_q [dbf_pkg::OUT_DEPTH];
  logic [dbf_pkg::OUT_CNT_W-1:0] in_flight;
  logic                          out_push, out_pop;

  logic                a_valid_q, b_valid_q;
  logic signed [45:0]  a_x1_q, a_y1_q, a_x2_q, a_y2_q;
  logic [15:0]         a_score_q, b_score_q;
  logic [7:0]          a_cls_q, b_cls_q;
  logic [28:0]         b_x1_q, b_y1_q, b_x2_q, b_y2_q;
  logic signed [45:0]  p_x1, p_y1, p_x2, p_y2;
  logic [28:0]         hi_x, hi_y;
  logic [29:0]         dx, dy;
  logic                keep;
  box_t                box_new;

  // room check covers every row already past the queue
  assign in_flight = out_count_q + dbf_pkg::OUT_CNT_W'(a_valid_q)
                     + dbf_pkg::OUT_CNT_W'(b_valid_q);
  assign q_pop_o   = !q_status_i.empty &&
                     (in_flight < dbf_pkg::OUT_CNT_W'(dbf_pkg::OUT_DEPTH));

  assign p_x1 = $signed(row_i.x_min) * $signed({1'b0, cfg_i.image_width});
  assign p_x2 = $signed(row_i.x_max) * $signed({1'b0, cfg_i.image_width});
  assign p_y1 = $signed(row_i.y_min) * $signed({1'b0, cfg_i.image_height});
  assign p_y2 = $signed(row_i.y_max) * $signed({1'b0, cfg_i.image_height});

  // stage a: scale normalized rows, sign-extend pixel rows
  always_ff @(posedge clk_i) begin
    a_x1_q    <= row_i.norm ? p_x1 : {{14{row_i.x_min[31]}}, row_i.x_min};
    a_x2_q    <= row_i.norm ? p_x2 : {{14{row_i.x_max[31]}}, row_i.x_max};
    a_y1_q    <= row_i.norm ? p_y1 : {{14{row_i.y_min[31]}}, row_i.y_min};
    a_y2_q    <= row_i.norm ? p_y2 : {{14{row_i.y_max[31]}}, row_i.y_max};
    a_score_q <= row_i.score;
    a_cls_q   <= 8'(row_i.cls);
  end

  // stage b: clamp to the image, which also covers the 32-bit saturation
  assign hi_x = {cfg_i.image_width, 16'b0};
  assign hi_y = {cfg_i.image_height, 16'b0};

  always_ff @(posedge clk_i) begin
    b_x1_q    <= clamp_dim(a_x1_q, hi_x);
    b_x2_q    <= clamp_dim(a_x2_q, hi_x);
    b_y1_q    <= clamp_dim(a_y1_q, hi_y);
    b_y2_q    <= clamp_dim(a_y2_q, hi_y);
    b_score_q <= a_score_q;
    b_cls_q   <= a_cls_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= q_pop_o;
      b_valid_q <= a_valid_q;
    end
  end

  // stage c: extent and small-box test
  assign dx   = {1'b0, b_x2_q} - {1'b0, b_x1_q};
  assign dy   = {1'b0, b_y2_q} - {1'b0, b_y1_q};
  assign keep = !dx[29] && !dy[29] &&
                (dx[28:0] >= dbf_pkg::ONE_PIXEL) && (dy[28:0] >= dbf_pkg::ONE_PIXEL);

  always_comb begin
    box_new.left   = b_x1_q;
    box_new.top    = b_y1_q;
    box_new.width  = dx[28:0];
    box_new.height = dy[28:0];
    box_new.conf   = b_score_q;
    box_new.cls    = b_cls_q;
  end

  assign out_push = b_valid_q && keep;
  assign out_pop  = pop && (out_count_q != '0);
  assign out_count_d = out_count_q + dbf_pkg::OUT_CNT_W'(out_push)
                       - dbf_pkg::OUT_CNT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_count_q <= '0;
      out_wr_q    <= '0;
      out_rd_q    <= '0;
    end else begin
      out_count_q <= out_count_d;
      if (out_push) begin
        out_wr_q <= out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q[out_wr_q] <= box_new;
    end
  end

  assign empty        = (out_count_q == '0);
  assign box_left_o   = out_q[out_rd_q].left;
  assign box_top_o    = out_q[out_rd_q].top;
  assign box_width_o  = out_q[out_rd_q].width;
  assign box_height_o = out_q[out_rd_q].height;
  assign confidence_o = out_q[out_rd_q].conf;
  assign class_id_o   = out_q[out_rd_q].cls;

endmodule

// File: rtl/dbf_checker.sv
`include "assert_macros.svh"

module dbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [28:0] box_left_o,
  input logic [28:0] box_width_o,
  input logic [28:0] box_height_o
);

  logic [29:0] right_edge;

  assign right_edge = {1'b0, box_left_o} + {1'b0, box_width_o};

  `DBF_ASSERT_IF(a_width_min, clk_i, rst_ni, !empty, box_width_o >= 29'h0001_0000, "box narrower than one pixel")
  `DBF_ASSERT_IF(a_height_min, clk_i, rst_ni, !empty, box_height_o >= 29'h0001_0000, "box shorter than one pixel")
  `DBF_ASSERT_IF(a_right_bound, clk_i, rst_ni, !empty, right_edge <= 30'h1FFF_0000, "box right edge past largest image")
  `DBF_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(box_left_o), "stalled result changed")

endmodule

bind detection_box_filter_core dbf_checker u_dbf_checker (.*);
